@@ rtl/core/history_window_statistics_core_assert.svh @@
// Assertion macros for the history window statistics core.
// Used by history_window_statistics_core.sv; no other dependencies.
`ifndef HISTORY_WINDOW_STATISTICS_CORE_ASSERT_SVH
`define HISTORY_WINDOW_STATISTICS_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define HWS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hws check failed: same-cycle rule");

// Next-cycle implication, disabled during reset.
`define HWS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hws check failed: next-cycle rule");

`endif

@@ rtl/core/hws_pkg.sv @@
// Shared types and constants for the history window statistics core.
// No dependencies; the files that use it refer to it by scoped names.
package hws_pkg;

    // Parameter defaults
    localparam int HISTORY_DEPTH_DEF = 8;
    localparam int SAMPLE_BITS_DEF   = 16;

    // Result field widths (fixed)
    localparam int OUT_W = 16;
    localparam int DEV_W = 15;
    localparam int CNT_W = 4;

    // Saturation limits and trend scale (Q8.8)
    localparam int DEV_MAX       = 32767;
    localparam int TREND_POS_MAX = 32767;
    localparam int TREND_NEG_MAX = 32768;
    localparam int TREND_SHIFT   = 8;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_ACCUM,
        ST_MEAN_GO,
        ST_MEAN_WAIT,
        ST_SQ_GO,
        ST_SQ_WAIT,
        ST_ROOT_GO,
        ST_ROOT_WAIT,
        ST_TREND_GO,
        ST_TREND_WAIT,
        ST_DONE
    } state_t;

    // Divider operand selection
    typedef enum logic [1:0] {
        DIV_MEAN,
        DIV_SQUARE,
        DIV_TREND
    } div_op_t;

    // Status of a serial arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } unit_status_t;

endpackage

@@ rtl/core/hws_in_if.sv @@
// Input stream interface: valid/ready plus one history sample item.
// Depends on hws_pkg for the default sample width.
interface hws_in_if #(
    parameter int SAMPLE_BITS = hws_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          has_sample;
    logic                          last;

    modport source (output valid, sample, has_sample, last, input ready);
    modport sink   (input valid, sample, has_sample, last, output ready);
endinterface

@@ rtl/core/hws_out_if.sv @@
// Result stream interface: valid/ready plus one window statistics item.
// Depends on hws_pkg for the result field widths.
interface hws_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [hws_pkg::OUT_W-1:0] mean;
    logic signed [hws_pkg::OUT_W-1:0] minimum;
    logic signed [hws_pkg::OUT_W-1:0] maximum;
    logic        [hws_pkg::DEV_W-1:0] deviation;
    logic signed [hws_pkg::OUT_W-1:0] trend;
    logic        [hws_pkg::CNT_W-1:0] sample_count;

    modport source (output valid, mean, minimum, maximum, deviation, trend, sample_count,
                    input ready);
    modport sink   (input valid, mean, minimum, maximum, deviation, trend, sample_count,
                    output ready);
endinterface

@@ rtl/core/hws_accum.sv @@
// Per-window accumulator: count, sum, sum of squares, min, max, half sums.
// Standalone; widths are handed down from the top level.
module hws_accum #(
    parameter int HISTORY_DEPTH = 8,
    parameter int SAMPLE_BITS   = 16,
    parameter int COUNT_W       = 4,
    parameter int SUM_W         = 19,
    parameter int SQUARE_W      = 34,
    parameter int HALF_W        = 18
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  logic                          clear,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    output logic        [COUNT_W-1:0]     count,
    output logic signed [SUM_W-1:0]       sum,
    output logic        [SQUARE_W-1:0]    square_sum,
    output logic signed [SAMPLE_BITS-1:0] minimum,
    output logic signed [SAMPLE_BITS-1:0] maximum,
    output logic signed [HALF_W-1:0]      older_sum,
    output logic signed [SAMPLE_BITS-1:0] middle
);

    localparam int HALF = HISTORY_DEPTH / 2;
    localparam logic [COUNT_W-1:0] DEPTH_C = COUNT_W'(HISTORY_DEPTH);
    localparam logic [COUNT_W-1:0] HALF_C  = COUNT_W'(HALF);
    localparam bit ODD_DEPTH = (HISTORY_DEPTH % 2) != 0;

    logic        [COUNT_W-1:0]     count_reg, count_next;
    logic signed [SUM_W-1:0]       sum_reg, sum_next;
    logic        [SQUARE_W-1:0]    sq_reg, sq_next;
    logic signed [SAMPLE_BITS-1:0] min_reg, min_next;
    logic signed [SAMPLE_BITS-1:0] max_reg, max_next;
    logic signed [HALF_W-1:0]      older_reg, older_next;
    logic signed [SAMPLE_BITS-1:0] middle_reg, middle_next;

    logic                          take;
    logic [SAMPLE_BITS-1:0]        mag;
    logic [2*SAMPLE_BITS-1:0]      mag_sq;

    // Next window state
    always_comb
    begin
        take        = load && (count_reg < DEPTH_C);
        mag         = sample[SAMPLE_BITS-1] ? (~sample + 1'b1) : sample;
        mag_sq      = mag * mag;
        count_next  = count_reg;
        sum_next    = sum_reg;
        sq_next     = sq_reg;
        min_next    = min_reg;
        max_next    = max_reg;
        older_next  = older_reg;
        middle_next = middle_reg;
        if (clear)
        begin
            count_next  = '0;
            sum_next    = '0;
            sq_next     = '0;
            min_next    = '0;
            max_next    = '0;
            older_next  = '0;
            middle_next = '0;
        end
        else if (take)
        begin
            if ((count_reg == '0) || (sample < min_reg))
            begin
                min_next = sample;
            end
            if ((count_reg == '0) || (sample > max_reg))
            begin
                max_next = sample;
            end
            // older half, or the middle sample of an odd window
            if (count_reg < HALF_C)
            begin
                older_next = older_reg + HALF_W'(sample);
            end
            else if (ODD_DEPTH && (count_reg == HALF_C))
            begin
                middle_next = sample;
            end
            sum_next   = sum_reg + SUM_W'(sample);
            sq_next    = sq_reg + SQUARE_W'(mag_sq);
            count_next = count_reg + COUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            sum_reg    <= '0;
            sq_reg     <= '0;
            min_reg    <= '0;
            max_reg    <= '0;
            older_reg  <= '0;
            middle_reg <= '0;
        end
        else
        begin
            count_reg  <= count_next;
            sum_reg    <= sum_next;
            sq_reg     <= sq_next;
            min_reg    <= min_next;
            max_reg    <= max_next;
            older_reg  <= older_next;
            middle_reg <= middle_next;
        end
    end

    assign count      = count_reg;
    assign sum        = sum_reg;
    assign square_sum = sq_reg;
    assign minimum    = min_reg;
    assign maximum    = max_reg;
    assign older_sum  = older_reg;
    assign middle     = middle_reg;

endmodule

@@ rtl/core/hws_serial_div.sv @@
// Bit-serial restoring divider, one quotient bit per cycle, unsigned.
// Depends on hws_pkg for the unit status struct.
module hws_serial_div #(
    parameter int DIVIDEND_W = 34,
    parameter int DIVISOR_W  = 19
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic [DIVIDEND_W-1:0] quotient,
    output hws_pkg::unit_status_t status
);

    localparam int STEP_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dsr_reg, dsr_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;

    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W+1:0]  diff;
    logic                  borrow;

    // One trial subtraction per cycle; dividend bits shift out as quotient shifts in
    always_comb
    begin
        shifted   = {rem_reg, quo_reg[DIVIDEND_W-1]};
        diff      = {1'b0, shifted} - {2'b00, dsr_reg};
        borrow    = diff[DIVISOR_W+1];
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            step_next = STEP_W'(DIVIDEND_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next  = {quo_reg[DIVIDEND_W-2:0], ~borrow};
            rem_next  = borrow ? shifted[DIVISOR_W-1:0] : diff[DIVISOR_W-1:0];
            step_next = step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

@@ rtl/core/hws_serial_sqrt.sv @@
// Digit-by-digit integer square root, one root bit (two radicand bits) per cycle.
// Depends on hws_pkg for the unit status struct. RADICAND_W must be even.
module hws_serial_sqrt #(
    parameter int RADICAND_W = 34
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [RADICAND_W-1:0]     radicand,
    output logic [RADICAND_W/2-1:0]   root,
    output hws_pkg::unit_status_t     status
);

    localparam int ROOT_W = RADICAND_W / 2;
    localparam int STEP_W = $clog2(ROOT_W + 1);

    logic [RADICAND_W-1:0] rad_reg, rad_next;
    logic [ROOT_W+1:0]     rem_reg, rem_next;
    logic [ROOT_W-1:0]     root_reg, root_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;

    logic [ROOT_W+3:0]     shifted;
    logic [ROOT_W+1:0]     trial;
    logic [ROOT_W+4:0]     diff;
    logic                  borrow;

    // Bring down two radicand bits, try (4 * root + 1)
    always_comb
    begin
        shifted   = {rem_reg, rad_reg[RADICAND_W-1 -: 2]};
        trial     = {root_reg, 2'b01};
        diff      = {1'b0, shifted} - {3'b000, trial};
        borrow    = diff[ROOT_W+4];
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            step_next = STEP_W'(ROOT_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rad_next  = {rad_reg[RADICAND_W-3:0], 2'b00};
            rem_next  = borrow ? shifted[ROOT_W+1:0] : diff[ROOT_W+1:0];
            root_next = {root_reg[ROOT_W-2:0], ~borrow};
            step_next = step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign root        = root_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

@@ rtl/core/history_window_statistics_core.sv @@
// Top level: window statistics over up to HISTORY_DEPTH signed Q8.8 samples.
// Depends on hws_pkg, hws_in_if, hws_out_if, hws_accum, hws_serial_div,
// hws_serial_sqrt and history_window_statistics_core_assert.svh.
//
//   Channel   Direction  Carries
//   samples   in         sample, has_sample, last
//   results   out        mean, minimum, maximum, deviation, trend, sample_count
//
// A sample item enters the accumulator in its transfer cycle. A closing item (last
// set) runs the mean divide, the E[x^2] divide, the root and the trend divide in
// that order before its result is valid; DIV_W = 34 at the defaults. The shared
// bit-serial divider (mean, E[x^2], trend) and the bit-serial root do this work.
// A window that is not full or has a zero mean skips the trend divide. A window
// with fewer than two samples stops after the mean.
// Reset empties the window and the output register; there is no clearing pass.
// Samples are taken while a result waits; after a closing item, samples.ready
// stays low until the new result is in the output register.
`include "history_window_statistics_core_assert.svh"

module history_window_statistics_core #(
    parameter int HISTORY_DEPTH = hws_pkg::HISTORY_DEPTH_DEF,
    parameter int SAMPLE_BITS   = hws_pkg::SAMPLE_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    hws_in_if.sink    samples,
    hws_out_if.source results
);

    // Derived widths
    localparam int OUT_W     = hws_pkg::OUT_W;
    localparam int DEV_W     = hws_pkg::DEV_W;
    localparam int CNT_W     = hws_pkg::CNT_W;
    localparam int HALF      = HISTORY_DEPTH / 2;
    localparam int LOG_D     = $clog2(HISTORY_DEPTH);
    localparam int COUNT_W   = $clog2(HISTORY_DEPTH + 1);
    localparam int SUM_W     = SAMPLE_BITS + LOG_D;
    localparam int SQUARE_W  = 2 * SAMPLE_BITS - 1 + LOG_D;
    localparam int HALF_W    = SAMPLE_BITS + $clog2(HALF);
    localparam int DIFF_W    = SUM_W + 2;
    localparam int NUM_W     = DIFF_W + hws_pkg::TREND_SHIFT;
    localparam int DEN_W     = SAMPLE_BITS + $clog2(HALF + 1);
    localparam int DIV_W     = (SQUARE_W > NUM_W) ? SQUARE_W : NUM_W;
    localparam int ROOT_IN_W = SQUARE_W + (SQUARE_W % 2);
    localparam int ROOT_W    = ROOT_IN_W / 2;
    localparam int DEV_CMP_W = ROOT_W + DEV_W;
    localparam logic [COUNT_W-1:0] DEPTH_C = COUNT_W'(HISTORY_DEPTH);
    localparam logic [COUNT_W-1:0] TWO_C   = COUNT_W'(2);

    // Sequencer
    hws_pkg::state_t  state_reg, state_next;
    hws_pkg::div_op_t div_op;
    logic             in_fire;
    logic             div_start;
    logic             sqrt_start;
    logic             out_load;
    logic             out_free;
    logic             trend_en;

    // Accumulator
    logic        [COUNT_W-1:0]     acc_count;
    logic signed [SUM_W-1:0]       acc_sum;
    logic        [SQUARE_W-1:0]    acc_square;
    logic signed [SAMPLE_BITS-1:0] acc_min;
    logic signed [SAMPLE_BITS-1:0] acc_max;
    logic signed [HALF_W-1:0]      acc_older;
    logic signed [SAMPLE_BITS-1:0] acc_middle;

    // Serial units
    logic [DIV_W-1:0]      div_dividend;
    logic [DEN_W-1:0]      div_divisor;
    logic [DIV_W-1:0]      div_quotient;
    hws_pkg::unit_status_t div_status;
    logic [ROOT_W-1:0]     sqrt_root;
    hws_pkg::unit_status_t sqrt_status;

    // Closing datapath
    logic signed [SAMPLE_BITS-1:0] mean_reg;
    logic [2*SAMPLE_BITS-1:0]      mean_sq_reg;
    logic [SQUARE_W-1:0]           var_reg;
    logic [DEV_W-1:0]              dev_reg;
    logic signed [OUT_W-1:0]       trend_reg;

    logic                          sum_neg;
    logic [SUM_W-1:0]              sum_mag;
    logic [SAMPLE_BITS-1:0]        mean_mag;
    logic signed [DIFF_W-1:0]      diff;
    logic [DIFF_W-1:0]             diff_mag;
    logic [NUM_W-1:0]              num_mag;
    logic [DEN_W-1:0]              den_mag;
    logic                          trend_neg;
    logic [SAMPLE_BITS-1:0]        q_mean;
    logic signed [SAMPLE_BITS-1:0] mean_new;
    logic [SQUARE_W-1:0]           e2;
    logic [SQUARE_W-1:0]           msq_ext;
    logic [SQUARE_W-1:0]           var_new;
    logic [DEV_CMP_W-1:0]          root_ext;
    logic [DEV_W-1:0]              dev_new;
    logic signed [OUT_W-1:0]       trend_new;

    // Output register
    logic                    out_valid_reg, out_valid_next;
    logic signed [OUT_W-1:0] out_mean_reg;
    logic signed [OUT_W-1:0] out_min_reg;
    logic signed [OUT_W-1:0] out_max_reg;
    logic [DEV_W-1:0]        out_dev_reg;
    logic signed [OUT_W-1:0] out_trend_reg;
    logic [CNT_W-1:0]        out_count_reg;

    assign in_fire  = samples.valid && samples.ready;
    assign out_free = !out_valid_reg || results.ready;

    hws_accum #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .SAMPLE_BITS   (SAMPLE_BITS),
        .COUNT_W       (COUNT_W),
        .SUM_W         (SUM_W),
        .SQUARE_W      (SQUARE_W),
        .HALF_W        (HALF_W)
    ) u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (in_fire && samples.has_sample),
        .clear      (out_load),
        .sample     (samples.sample),
        .count      (acc_count),
        .sum        (acc_sum),
        .square_sum (acc_square),
        .minimum    (acc_min),
        .maximum    (acc_max),
        .older_sum  (acc_older),
        .middle     (acc_middle)
    );

    hws_serial_div #(
        .DIVIDEND_W (DIV_W),
        .DIVISOR_W  (DEN_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .status   (div_status)
    );

    hws_serial_sqrt #(
        .RADICAND_W (ROOT_IN_W)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (ROOT_IN_W'(var_reg)),
        .root     (sqrt_root),
        .status   (sqrt_status)
    );

    // Operand magnitudes and signs
    always_comb
    begin
        sum_neg   = acc_sum[SUM_W-1];
        sum_mag   = sum_neg ? (~acc_sum + 1'b1) : acc_sum;
        mean_mag  = mean_reg[SAMPLE_BITS-1] ? (~mean_reg + 1'b1) : mean_reg;
        diff      = DIFF_W'(acc_sum) - DIFF_W'(acc_older) - DIFF_W'(acc_older)
                    - DIFF_W'(acc_middle);
        diff_mag  = diff[DIFF_W-1] ? (~diff + 1'b1) : diff;
        num_mag   = NUM_W'(diff_mag) << hws_pkg::TREND_SHIFT;
        den_mag   = DEN_W'(mean_mag) * DEN_W'(HALF);
        trend_neg = diff[DIFF_W-1] ^ mean_reg[SAMPLE_BITS-1];
        trend_en  = (acc_count == DEPTH_C) && (mean_reg != '0);
    end

    // Divider operand select
    always_comb
    begin
        unique case (div_op)
            hws_pkg::DIV_MEAN:
            begin
                div_dividend = DIV_W'(sum_mag);
                div_divisor  = DEN_W'(acc_count);
            end
            hws_pkg::DIV_SQUARE:
            begin
                div_dividend = DIV_W'(acc_square);
                div_divisor  = DEN_W'(acc_count);
            end
            hws_pkg::DIV_TREND:
            begin
                div_dividend = DIV_W'(num_mag);
                div_divisor  = den_mag;
            end
            default:
            begin
                div_dividend = '0;
                div_divisor  = '0;
            end
        endcase
    end

    // Result formatting: sign restore, variance clamp, saturation
    always_comb
    begin
        q_mean   = div_quotient[SAMPLE_BITS-1:0];
        mean_new = sum_neg ? (~q_mean + 1'b1) : q_mean;
        e2       = div_quotient[SQUARE_W-1:0];
        msq_ext  = SQUARE_W'(mean_sq_reg);
        var_new  = (e2 > msq_ext) ? (e2 - msq_ext) : '0;
        root_ext = DEV_CMP_W'(sqrt_root);
        dev_new  = (root_ext > DEV_CMP_W'(hws_pkg::DEV_MAX)) ? DEV_W'(hws_pkg::DEV_MAX)
                                                             : root_ext[DEV_W-1:0];
        if (!trend_neg)
        begin
            trend_new = (div_quotient > DIV_W'(hws_pkg::TREND_POS_MAX))
                        ? OUT_W'(hws_pkg::TREND_POS_MAX) : div_quotient[OUT_W-1:0];
        end
        else
        begin
            trend_new = (div_quotient > DIV_W'(hws_pkg::TREND_NEG_MAX))
                        ? OUT_W'(-hws_pkg::TREND_NEG_MAX)
                        : (~div_quotient[OUT_W-1:0] + 1'b1);
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hws_pkg::ST_ACCUM:
            begin
                if (in_fire && samples.last)
                begin
                    state_next = hws_pkg::ST_MEAN_GO;
                end
            end
            hws_pkg::ST_MEAN_GO:
            begin
                state_next = (acc_count == '0) ? hws_pkg::ST_DONE : hws_pkg::ST_MEAN_WAIT;
            end
            hws_pkg::ST_MEAN_WAIT:
            begin
                if (div_status.done)
                begin
                    state_next = (acc_count < TWO_C) ? hws_pkg::ST_DONE : hws_pkg::ST_SQ_GO;
                end
            end
            hws_pkg::ST_SQ_GO:
            begin
                state_next = hws_pkg::ST_SQ_WAIT;
            end
            hws_pkg::ST_SQ_WAIT:
            begin
                if (div_status.done)
                begin
                    state_next = hws_pkg::ST_ROOT_GO;
                end
            end
            hws_pkg::ST_ROOT_GO:
            begin
                state_next = hws_pkg::ST_ROOT_WAIT;
            end
            hws_pkg::ST_ROOT_WAIT:
            begin
                if (sqrt_status.done)
                begin
                    state_next = hws_pkg::ST_TREND_GO;
                end
            end
            hws_pkg::ST_TREND_GO:
            begin
                state_next = trend_en ? hws_pkg::ST_TREND_WAIT : hws_pkg::ST_DONE;
            end
            hws_pkg::ST_TREND_WAIT:
            begin
                if (div_status.done)
                begin
                    state_next = hws_pkg::ST_DONE;
                end
            end
            hws_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = hws_pkg::ST_ACCUM;
                end
            end
            default:
            begin
                state_next = hws_pkg::ST_ACCUM;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        samples.ready = 1'b0;
        div_start     = 1'b0;
        div_op        = hws_pkg::DIV_MEAN;
        sqrt_start    = 1'b0;
        out_load      = 1'b0;
        unique case (state_reg)
            hws_pkg::ST_ACCUM:
            begin
                samples.ready = 1'b1;
            end
            hws_pkg::ST_MEAN_GO:
            begin
                div_start = (acc_count != '0);
                div_op    = hws_pkg::DIV_MEAN;
            end
            hws_pkg::ST_SQ_GO:
            begin
                div_start = 1'b1;
                div_op    = hws_pkg::DIV_SQUARE;
            end
            hws_pkg::ST_ROOT_GO:
            begin
                sqrt_start = 1'b1;
            end
            hws_pkg::ST_TREND_GO:
            begin
                div_start = trend_en;
                div_op    = hws_pkg::DIV_TREND;
            end
            hws_pkg::ST_DONE:
            begin
                out_load = out_free;
            end
            default:
            begin
                samples.ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hws_pkg::ST_ACCUM;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Closing registers; mean, deviation and trend are cleared as each close starts
    always_ff @(posedge clk)
    begin
        mean_sq_reg <= mean_mag * mean_mag;
        if (state_reg == hws_pkg::ST_MEAN_GO)
        begin
            mean_reg  <= '0;
            dev_reg   <= '0;
            trend_reg <= '0;
        end
        if ((state_reg == hws_pkg::ST_MEAN_WAIT) && div_status.done)
        begin
            mean_reg <= mean_new;
        end
        if ((state_reg == hws_pkg::ST_SQ_WAIT) && div_status.done)
        begin
            var_reg <= var_new;
        end
        if ((state_reg == hws_pkg::ST_ROOT_WAIT) && sqrt_status.done)
        begin
            dev_reg <= dev_new;
        end
        if ((state_reg == hws_pkg::ST_TREND_WAIT) && div_status.done)
        begin
            trend_reg <= trend_new;
        end
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_mean_reg  <= OUT_W'(mean_reg);
            out_min_reg   <= OUT_W'(acc_min);
            out_max_reg   <= OUT_W'(acc_max);
            out_dev_reg   <= dev_reg;
            out_trend_reg <= trend_reg;
            out_count_reg <= CNT_W'(acc_count);
        end
    end

    assign results.valid        = out_valid_reg;
    assign results.mean         = out_mean_reg;
    assign results.minimum      = out_min_reg;
    assign results.maximum      = out_max_reg;
    assign results.deviation    = out_dev_reg;
    assign results.trend        = out_trend_reg;
    assign results.sample_count = out_count_reg;

    // Checks
    `HWS_ASSERT_NOW(a_div_start_idle, clk, rst_n, div_start, !div_status.busy)
    `HWS_ASSERT_NOW(a_units_idle_accum, clk, rst_n, state_reg == hws_pkg::ST_ACCUM, !div_status.busy && !sqrt_status.busy)
    `HWS_ASSERT_NEXT(a_window_cleared, clk, rst_n, out_load, acc_count == '0)
    `HWS_ASSERT_NEXT(a_close_stalls_input, clk, rst_n, in_fire && samples.last, !samples.ready)

endmodule
